@@ design/deq_pkg.sv @@
// shared types, request codes and status codes for the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // default number of entries
  localparam int DEFAULT_DEPTH = 16;

  // request codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_SHOW       = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // one request
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] item_value;
  } deq_req_t;

  // one result
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last_of_run;
  } deq_rsp_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHOW,
    ST_BACK
  } deq_state_t;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_R,
    OP_SHIFT_L,
    OP_ROTATE,
    OP_APPEND
  } deq_op_t;

  // broadcast from the sequencer to the row of cells
  typedef struct packed {
    deq_op_t            op;
    logic signed [31:0] item;
    logic signed [31:0] head;
  } deq_cell_ctrl_t;

  // what the row shows the sequencer
  typedef struct packed {
    logic               empty;
    logic               full;
    logic signed [31:0] head_value;
  } deq_stat_t;

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// one storage cell of the queue row, talking to its left and right neighbors
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire deq_pkg::deq_cell_ctrl_t  ctrl,
  input  wire logic                     left_valid,
  input  wire logic signed [31:0]       left_value,
  input  wire logic                     right_valid,
  input  wire logic signed [31:0]       right_value,
  output logic                          valid,
  output logic signed [31:0]            value
);

  logic               valid_next;
  logic signed [31:0] value_next;

  // cell update for the broadcast operation
  always_comb begin
    valid_next = valid;
    value_next = value;
    case (ctrl.op)
      deq_pkg::OP_SHIFT_R: begin
        valid_next = left_valid;
        value_next = left_value;
      end
      deq_pkg::OP_SHIFT_L: begin
        valid_next = right_valid;
        value_next = right_value;
      end
      deq_pkg::OP_ROTATE: begin
        // live cells move left, the tail cell takes the old front
        if (right_valid) begin
          value_next = right_value;
        end else if (valid) begin
          value_next = ctrl.head;
        end
      end
      deq_pkg::OP_APPEND: begin
        // first free cell behind the tail takes the new item
        if (!valid && left_valid) begin
          valid_next = 1'b1;
          value_next = ctrl.item;
        end
      end
      default: begin
        valid_next = valid;
        value_next = value;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ design/deq_ctrl.sv @@
// request sequencer: decodes requests, drives the cell row and forms results
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire deq_pkg::deq_req_t        request,
  input  wire deq_pkg::deq_stat_t       stat,
  output logic                          busy,
  output deq_pkg::deq_cell_ctrl_t       ctrl,
  output logic                          done,
  output deq_pkg::deq_rsp_t             result
);

  localparam int CW = $clog2(DEPTH + 1);

  deq_pkg::deq_state_t state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       remaining, remaining_next;
  logic                done_next;
  deq_pkg::deq_rsp_t   result_next;
  deq_pkg::deq_op_t    op;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (start) begin
          if (request.func == deq_pkg::FN_SHOW && !stat.empty) begin
            state_next = deq_pkg::ST_SHOW;
          end else if (request.func == deq_pkg::FN_POP_BACK && !stat.empty &&
                       count != CW'(1)) begin
            state_next = deq_pkg::ST_BACK;
          end
        end
      end
      deq_pkg::ST_SHOW: begin
        if (remaining == CW'(1)) begin
          state_next = deq_pkg::ST_IDLE;
        end
      end
      deq_pkg::ST_BACK: begin
        if (remaining == '0) begin
          state_next = deq_pkg::ST_IDLE;
        end
      end
      default: state_next = deq_pkg::ST_IDLE;
    endcase
  end

  // outputs, counters and result formation
  always_comb begin
    op             = deq_pkg::OP_HOLD;
    count_next     = count;
    remaining_next = remaining;
    done_next      = 1'b0;
    result_next    = '{out_value: '0, status: deq_pkg::STAT_OK, last_of_run: 1'b1};
    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (start) begin
          case (request.func)
            deq_pkg::FN_PUSH_FRONT: begin
              if (stat.full) begin
                done_next          = 1'b1;
                result_next.status = deq_pkg::STAT_FULL;
              end else begin
                op         = deq_pkg::OP_SHIFT_R;
                count_next = count + CW'(1);
              end
            end
            deq_pkg::FN_PUSH_BACK: begin
              if (stat.full) begin
                done_next          = 1'b1;
                result_next.status = deq_pkg::STAT_FULL;
              end else begin
                op         = deq_pkg::OP_APPEND;
                count_next = count + CW'(1);
              end
            end
            deq_pkg::FN_POP_FRONT: begin
              done_next = 1'b1;
              if (stat.empty) begin
                result_next.status = deq_pkg::STAT_EMPTY;
              end else begin
                result_next.out_value = stat.head_value;
                op                    = deq_pkg::OP_SHIFT_L;
                count_next            = count - CW'(1);
              end
            end
            deq_pkg::FN_POP_BACK: begin
              if (stat.empty) begin
                done_next          = 1'b1;
                result_next.status = deq_pkg::STAT_EMPTY;
              end else if (count == CW'(1)) begin
                // single entry: back is also front
                done_next             = 1'b1;
                result_next.out_value = stat.head_value;
                op                    = deq_pkg::OP_SHIFT_L;
                count_next            = '0;
              end else begin
                remaining_next = count - CW'(1);
              end
            end
            deq_pkg::FN_SHOW: begin
              if (stat.empty) begin
                done_next          = 1'b1;
                result_next.status = deq_pkg::STAT_EMPTY;
              end else begin
                remaining_next = count;
              end
            end
            default: begin
              op = deq_pkg::OP_HOLD;
            end
          endcase
        end
      end
      deq_pkg::ST_SHOW: begin
        // emit the front and rotate it to the tail
        done_next               = 1'b1;
        result_next.out_value   = stat.head_value;
        result_next.last_of_run = (remaining == CW'(1));
        op                      = deq_pkg::OP_ROTATE;
        remaining_next          = remaining - CW'(1);
      end
      deq_pkg::ST_BACK: begin
        // rotate until the back entry sits at the front, then pop it
        if (remaining != '0) begin
          op             = deq_pkg::OP_ROTATE;
          remaining_next = remaining - CW'(1);
        end else begin
          done_next             = 1'b1;
          result_next.out_value = stat.head_value;
          op                    = deq_pkg::OP_SHIFT_L;
          count_next            = count - CW'(1);
        end
      end
      default: begin
        op = deq_pkg::OP_HOLD;
      end
    endcase
  end

  assign busy      = (state != deq_pkg::ST_IDLE);
  assign ctrl.op   = op;
  assign ctrl.item = request.item_value;
  assign ctrl.head = stat.head_value;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::ST_IDLE;
      count     <= '0;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      done      <= done_next;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

@@ design/double_ended_queue.sv @@
// double-ended queue top level: sequencer plus a row of DEPTH storage cells
//
//   port group        dir   role
//   start/request     in    request, taken when start is high and busy is low
//   busy              out   high while a show or multi-entry pop back is in progress
//   done/result       out   one result per cycle, held for exactly one cycle
//
// push front, push back and pop front leave busy low.
// pop back of a single entry also leaves busy low; with more entries busy
// stays high after acceptance while the row rotates count-1 times to bring
// the back entry to the front, then pops it.
// show gives count results, one per cycle, rotating the row once round.
// each result is registered and appears in the cycle after the one that forms it.
// rst clears the sequencer and the occupancy flags; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire deq_pkg::deq_req_t  request,
  output logic                    busy,
  output logic                    done,
  output deq_pkg::deq_rsp_t       result
);

  deq_pkg::deq_cell_ctrl_t ctrl;
  deq_pkg::deq_stat_t      stat;
  logic                    cell_valid [DEPTH];
  logic signed [31:0]      cell_value [DEPTH];

  // row status seen by the sequencer
  assign stat.empty      = !cell_valid[0];
  assign stat.full       = cell_valid[DEPTH-1];
  assign stat.head_value = cell_value[0];

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl),
    .done    (done),
    .result  (result)
  );

  // row of cells, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               lv, rv;
    logic signed [31:0] lval, rval;

    if (i == 0) begin : g_first
      assign lv   = 1'b1;
      assign lval = ctrl.item;
    end else begin : g_mid_l
      assign lv   = cell_valid[i-1];
      assign lval = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_mid_r
      assign rv   = cell_valid[i+1];
      assign rval = cell_value[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (lv),
      .left_value  (lval),
      .right_valid (rv),
      .right_value (rval),
      .valid       (cell_valid[i]),
      .value       (cell_value[i])
    );
  end

endmodule

`default_nettype wire

@@ design/deq_checker.sv @@
// port-level checks for the double-ended queue and their bind
`timescale 1ns / 1ps
`default_nettype none

module deq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire deq_pkg::deq_req_t  request,
  input wire logic               busy,
  input wire logic               done,
  input wire deq_pkg::deq_rsp_t  result
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or done after reset");

  // a failed request carries a zero value and ends its run
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != deq_pkg::STAT_OK) |->
      (result.out_value == '0 && result.last_of_run))
    else $error("failed result not zero or not last");

  // a push only ever reports a full queue
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.func == deq_pkg::FN_PUSH_FRONT ||
                        request.func == deq_pkg::FN_PUSH_BACK)) |=>
      (!done || result.status == deq_pkg::STAT_FULL))
    else $error("push gave an unexpected result");

  // unused request codes are dropped silently
  a_unused_code: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.func != deq_pkg::FN_PUSH_FRONT &&
     request.func != deq_pkg::FN_PUSH_BACK && request.func != deq_pkg::FN_POP_FRONT &&
     request.func != deq_pkg::FN_POP_BACK && request.func != deq_pkg::FN_SHOW) |=>
      (!done && !busy))
    else $error("unused code produced activity");

  // a run of results has no gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_of_run) |=> done)
    else $error("gap inside a result run");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .request (request),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire
